### design/ir_remote_frame_encoder_assert.svh
// Assertion macros for the frame encoder checker.
`ifndef IR_REMOTE_FRAME_ENCODER_ASSERT_SVH
`define IR_REMOTE_FRAME_ENCODER_ASSERT_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define IRFE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define IRFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/irfe_pkg.sv
// Types, pulse word constants and sizes for the IR frame encoder.
`default_nettype none

package irfe_pkg;

  // Request and result payloads
  typedef struct packed {
    logic       func;
    logic [5:0] bit_count;
    logic [7:0] toggle;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] cmd_ext1;
    logic [7:0] cmd_ext2;
  } req_t;

  typedef struct packed {
    logic [7:0] word_first;
    logic [7:0] word_second;
    logic       last;
  } result_t;

  // Frame kind
  typedef enum logic [1:0] {
    MODE_NEC = 2'd0,
    MODE_RC5 = 2'd1,
    MODE_RC6 = 2'd2
  } mode_e;

  // Classified frame handed from the front end to the sequencer.
  // bits[k] is the k-th payload bit on air, already in its final polarity.
  typedef struct packed {
    mode_e       mode;
    logic [5:0]  nbits;
    logic        bit_a;   // RC5 field bit / RC6 trailer bit
    logic        bit_b;   // RC5 toggle bit
    logic [31:0] bits;
  } desc_t;

  localparam int unsigned IRFE_QDEPTH = 2;

  localparam logic [5:0] MAX_BITS     = 6'd32;
  localparam logic [5:0] RC5_MAX_BITS = 6'd12;
  localparam logic [5:0] HDR_LEN_NEC  = 6'd3;
  localparam logic [5:0] HDR_LEN_RC5  = 6'd3;
  localparam logic [5:0] HDR_LEN_RC6  = 6'd6;

  // Pulse words: bit 7 is carrier on, bits 6..0 ticks
  localparam logic [7:0] LEVEL_ON     = 8'h80;
  localparam logic [7:0] W_END        = 8'h00;
  localparam logic [7:0] W_NEC_HDR    = 8'hFF;
  localparam logic [7:0] W_NEC_HDR2   = 8'hDC;
  localparam logic [7:0] W_NEC_GAP    = 8'h7F;
  localparam logic [7:0] W_NEC_GAP2   = 8'h2E;
  localparam logic [7:0] W_NEC_MARK   = 8'h96;
  localparam logic [7:0] W_NEC_ONE    = 8'h40;
  localparam logic [7:0] W_NEC_ZERO   = 8'h16;
  localparam logic [7:0] HALF_RC5     = 8'h22;
  localparam logic [7:0] HALF_RC6     = 8'h11;
  localparam logic [7:0] HALF_RC6_TR  = 8'h22;
  localparam logic [7:0] W_RC6_LEAD   = 8'h66 | LEVEL_ON;

  function automatic logic [5:0] hdr_len(mode_e mode);
    logic [5:0] len;
    unique case (mode)
      MODE_NEC: len = HDR_LEN_NEC;
      MODE_RC5: len = HDR_LEN_RC5;
      MODE_RC6: len = HDR_LEN_RC6;
      default:  len = HDR_LEN_NEC;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### design/irfe_front.sv
// Front end: classifies a request into a frame descriptor.
`default_nettype none

module irfe_front
  import irfe_pkg::*;
(
  input  req_t  req_i,
  output desc_t desc_o
);

  logic [5:0]  nsat;
  logic [31:0] rc5_msb;
  logic [31:0] rc6_msb;
  logic [31:0] rc5_seq;
  logic [31:0] rc6_seq;

  // Saturate the bit count
  assign nsat = (req_i.bit_count > MAX_BITS) ? MAX_BITS : req_i.bit_count;

  // RC payloads, MSB first on air
  assign rc5_msb = {req_i.addr[4:0], req_i.cmd[5:0], req_i.cmd_ext1, req_i.cmd_ext2, 5'd0};
  assign rc6_msb = ~{req_i.addr, req_i.cmd, req_i.cmd_ext1, req_i.cmd_ext2};

  // Reorder so that bit 0 goes out first
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      rc5_seq[i] = rc5_msb[31 - i];
      rc6_seq[i] = rc6_msb[31 - i];
    end
  end

  // Frame kind selection
  always_comb begin
    desc_o = '0;
    if (!req_i.func) begin
      desc_o.mode  = MODE_NEC;
      desc_o.nbits = MAX_BITS;
      desc_o.bits  = {~req_i.cmd, req_i.cmd, ~req_i.addr, req_i.addr};
    end else if (nsat <= RC5_MAX_BITS) begin
      desc_o.mode  = MODE_RC5;
      desc_o.nbits = nsat;
      desc_o.bit_a = req_i.cmd[6];
      desc_o.bit_b = |req_i.toggle;
      desc_o.bits  = rc5_seq;
    end else begin
      desc_o.mode  = MODE_RC6;
      desc_o.nbits = nsat;
      desc_o.bit_a = ~req_i.toggle[6];
      desc_o.bits  = rc6_seq;
    end
  end

endmodule

`default_nettype wire

### design/irfe_queue.sv
// Short descriptor queue between the front end and the sequencer.
`default_nettype none

module irfe_queue
  import irfe_pkg::*;
#(
  parameter int unsigned Depth = IRFE_QDEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  input  logic  pop_i,
  output desc_t pop_data_o,
  output logic  empty_o,
  output logic  full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == CntW'(Depth));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### design/irfe_back.sv
// Back end: emits a descriptor's frame, one word pair per active cycle.
`default_nettype none

module irfe_back
  import irfe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  desc_t   q_data_i,
  output logic    q_pop_o,
  output logic    res_valid_o,
  output result_t res_o
);

  logic        act_q, act_d;
  mode_e       mode_q, mode_d;
  logic        bit_a_q, bit_a_d;
  logic        bit_b_q, bit_b_d;
  logic [31:0] bits_q, bits_d;
  logic [5:0]  pos_q, pos_d;
  logic [5:0]  end_q, end_d;
  logic        valid_q;
  result_t     res_q, res_d;
  logic        in_hdr, at_end;

  // Manchester pair: a one is low then high
  function automatic logic [15:0] manch(logic one, logic [7:0] half);
    return one ? {half, half | LEVEL_ON} : {half | LEVEL_ON, half};
  endfunction

  // Header pairs per frame kind
  function automatic logic [15:0] hdr_pair(mode_e mode, logic [2:0] idx,
                                           logic a, logic b);
    logic [15:0] w;
    w = {W_END, W_END};
    unique case (mode)
      MODE_NEC: begin
        if (idx == 3'd0) w = {W_NEC_HDR, W_NEC_HDR};
        else if (idx == 3'd1) w = {W_NEC_HDR2, W_NEC_GAP};
        else w = {W_NEC_GAP2, W_NEC_MARK};
      end
      MODE_RC5: begin
        if (idx == 3'd0) w = {HALF_RC5 | LEVEL_ON, HALF_RC5};
        else if (idx == 3'd1) w = manch(a, HALF_RC5);
        else w = manch(b, HALF_RC5);
      end
      MODE_RC6: begin
        if (idx == 3'd0) w = {W_RC6_LEAD, HALF_RC6_TR};
        else if (idx == 3'd1) w = {HALF_RC6 | LEVEL_ON, HALF_RC6};
        else if (idx == 3'd5) w = manch(a, HALF_RC6_TR);
        else w = {HALF_RC6, HALF_RC6 | LEVEL_ON};
      end
      default: w = {W_END, W_END};
    endcase
    return w;
  endfunction

  // Payload bit pair
  function automatic logic [15:0] bit_pair(mode_e mode, logic one);
    logic [15:0] w;
    unique case (mode)
      MODE_NEC: w = {one ? W_NEC_ONE : W_NEC_ZERO, W_NEC_MARK};
      MODE_RC5: w = manch(one, HALF_RC5);
      MODE_RC6: w = manch(one, HALF_RC6);
      default:  w = {W_END, W_END};
    endcase
    return w;
  endfunction

  // First word of the closing pair, before the terminating zero word
  function automatic logic [7:0] end_first(mode_e mode);
    logic [7:0] w;
    unique case (mode)
      MODE_NEC: w = W_NEC_ZERO;
      MODE_RC5: w = HALF_RC5;
      MODE_RC6: w = HALF_RC6;
      default:  w = W_END;
    endcase
    return w;
  endfunction

  assign in_hdr  = (pos_q < hdr_len(mode_q));
  assign at_end  = (pos_q == end_q);
  assign q_pop_o = (!act_q || at_end) && !q_empty_i;

  // Current pair
  always_comb begin
    res_d.last = 1'b0;
    if (in_hdr) begin
      {res_d.word_first, res_d.word_second} = hdr_pair(mode_q, pos_q[2:0], bit_a_q, bit_b_q);
    end else if (at_end) begin
      {res_d.word_first, res_d.word_second} = {end_first(mode_q), W_END};
      res_d.last = 1'b1;
    end else begin
      {res_d.word_first, res_d.word_second} = bit_pair(mode_q, bits_q[0]);
    end
  end

  // Sequencer: loads a frame when idle or at the current frame's end
  always_comb begin
    act_d   = act_q;
    mode_d  = mode_q;
    bit_a_d = bit_a_q;
    bit_b_d = bit_b_q;
    bits_d  = bits_q;
    pos_d   = pos_q;
    end_d   = end_q;
    if (!act_q || at_end) begin
      act_d = q_pop_o;
      if (q_pop_o) begin
        mode_d  = q_data_i.mode;
        bit_a_d = q_data_i.bit_a;
        bit_b_d = q_data_i.bit_b;
        bits_d  = q_data_i.bits;
        pos_d   = '0;
        end_d   = hdr_len(q_data_i.mode) + q_data_i.nbits;
      end
    end else begin
      pos_d = pos_q + 6'd1;
      if (!in_hdr) begin
        bits_d = {1'b0, bits_q[31:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      valid_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    bit_a_q <= bit_a_d;
    bit_b_q <= bit_b_d;
    bits_q  <= bits_d;
    pos_q   <= pos_d;
    end_q   <= end_d;
    res_q   <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### design/ir_remote_frame_encoder.sv
// Top level of the IR remote-control frame encoder.
//
// A request (NEC, or RC5/RC6 chosen by bit count) is taken at a rising
// edge where start_i is high and busy_o is low. It is classified and put
// in a short queue; the sequencer then emits the frame as pairs of 8-bit
// pulse words, one pair per cycle on result_o, each marked by a one-cycle
// result_valid_o strobe. The pair holding the terminating zero word has
// last set. Frames are NEC 36 results, RC5 4 + n, RC6 7 + n results,
// n being the bit count saturated at 32, so at most 39 results per frame.
// Each request passes through the queue and the sequencer's frame
// registers before its first pair reaches the output register;
// consecutive frames follow with no gap. busy_o is high only
// while the queue is full, so a new request is taken while a frame is
// still being sent. Results cannot be held off by the receiver.
// Reset empties the queue and idles the sequencer, dropping any frame
// in progress; nothing is invented across it or needs clearing afterward.
`default_nettype none

module ir_remote_frame_encoder
  import irfe_pkg::*;
#(
  parameter int unsigned QDepth = IRFE_QDEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  req_t    req_i,
  output logic    busy_o,
  output logic    result_valid_o,
  output result_t result_o
);

  desc_t front_desc;
  desc_t q_data;
  logic  q_empty, q_full, q_pop;

  irfe_front u_front (
    .req_i  (req_i),
    .desc_o (front_desc)
  );

  irfe_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start_i),
    .push_data_i (front_desc),
    .pop_i       (q_pop),
    .pop_data_o  (q_data),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  irfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

  assign busy_o = q_full;

endmodule

`default_nettype wire

### design/irfe_checker.sv
// Port-level checker for the IR frame encoder and its bind.
`default_nettype none

`include "ir_remote_frame_encoder_assert.svh"

module irfe_checker
  import irfe_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    res_valid_i,
  input result_t res_i
);

  logic first_of_frame;
  logic mid_frame_q, mid_frame_d;

  // Track whether the previous cycle carried a non-final pair
  assign mid_frame_d = res_valid_i && !res_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_frame_q <= 1'b0;
    end else begin
      mid_frame_q <= mid_frame_d;
    end
  end

  // A pair that does not directly follow a non-final pair opens a frame
  assign first_of_frame = res_valid_i && !mid_frame_q;

  // The closing pair carries the zero word second
  `IRFE_ASSERT_SAME(a_last_zero, res_valid_i && res_i.last, res_i.word_second == W_END, "last pair without zero word")

  // Only the closing pair contains a zero word
  `IRFE_ASSERT_SAME(a_no_early_zero, res_valid_i && !res_i.last, res_i.word_first != W_END && res_i.word_second != W_END, "zero word before end of frame")

  // A frame is sent without gaps
  `IRFE_ASSERT_NEXT(a_no_gap, res_valid_i && !res_i.last, res_valid_i, "gap inside a frame")

  // Every frame opens with carrier on
  `IRFE_ASSERT_SAME(a_open_on, first_of_frame, res_i.word_first[7], "frame opens with carrier off")

endmodule

bind ir_remote_frame_encoder irfe_checker u_irfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_valid_o),
  .res_i       (result_o)
);

`default_nettype wire
